// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue unit.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DATA_W       = 16;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;
   localparam int COUNT_PORT_W = 5;

   localparam logic signed [DATA_W-1:0] PRI_MAX = 16'sh7fff;
   localparam logic signed [DATA_W-1:0] PRI_MIN = 16'sh8000;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_AGE_UP   = 2'd2,
      OP_AGE_DOWN = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE       = 2'd0,
      STAT_FULL       = 2'd1,
      STAT_EMPTY      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PURGE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DP_NONE,
      DP_EXEC,
      DP_PURGE
   } dp_op_type;

   // controller -> datapath
   typedef struct packed {
      logic      capture;
      dp_op_type op;
      logic      load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   empty;
      logic   head_neg;
   } dp_status_type;

   // max tree node: largest value and largest priority over valid entries
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] vmax;
      logic signed [DATA_W-1:0] pmax;
   } node_type;

   function automatic node_type node_merge(input node_type a, input node_type b);
      node_type r;
      if (a.valid && b.valid) begin
         r.valid = 1'b1;
         r.vmax  = (b.vmax > a.vmax) ? b.vmax : a.vmax;
         r.pmax  = (b.pmax > a.pmax) ? b.pmax : a.pmax;
      end else if (b.valid) begin
         r = b;
      end else begin
         r = a;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/spq_max_tree.sv =====
// ----------------------------------------------------------------------------
// spq_max_tree
// Registered reduction tree: largest value and largest (tail) priority over
// the occupied slots. One register level per tree level.
// ----------------------------------------------------------------------------
module spq_max_tree
   import spq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int CW    = 5
) (
   input  logic                     clock,
   input  logic signed [DATA_W-1:0] val_q [DEPTH],
   input  logic signed [DATA_W-1:0] pri_q [DEPTH],
   input  logic [CW-1:0]            count,
   output node_type                 root
);

   localparam int LEVELS = $clog2(DEPTH);
   localparam int LEAVES = 1 << LEVELS;

   node_type leaf [LEAVES];
   node_type node_ff [1:LEAVES-1];

   genvar i, k;
   generate
      for (i = 0; i < LEAVES; i++) begin : g_leaf
         if (i < DEPTH) begin : g_used
            assign leaf[i].valid = (CW'(i) < count);
            assign leaf[i].vmax  = val_q[i];
            assign leaf[i].pmax  = pri_q[i];
         end else begin : g_pad
            assign leaf[i] = '0;
         end
      end

      for (k = 1; k < LEAVES; k++) begin : g_node
         if (2 * k >= LEAVES) begin : g_bottom
            always_ff @(posedge clock) begin
               node_ff[k] <= node_merge(leaf[2*k-LEAVES], leaf[2*k+1-LEAVES]);
            end
         end else begin : g_inner
            always_ff @(posedge clock) begin
               node_ff[k] <= node_merge(node_ff[2*k], node_ff[2*k+1]);
            end
         end
      end
   endgenerate

   assign root = node_ff[1];

endmodule

// ===== rtl/core/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted entry array with parallel shift, entry count, request capture and
// the result register.
// ----------------------------------------------------------------------------
module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int CW    = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output dp_status_type              dp_stat,
   input  logic [OP_W-1:0]            req_operation,
   input  logic signed [DATA_W-1:0]   req_item_value,
   input  logic signed [DATA_W-1:0]   req_item_priority,
   output logic signed [DATA_W-1:0]   val_q [DEPTH],
   output logic signed [DATA_W-1:0]   pri_q [DEPTH],
   output logic [CW-1:0]              count,
   input  node_type                   root,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_PORT_W-1:0]    rsp_entry_count,
   output logic signed [DATA_W-1:0]   rsp_head_value,
   output logic signed [DATA_W-1:0]   rsp_head_priority,
   output logic signed [DATA_W-1:0]   rsp_largest_value,
   output logic signed [DATA_W-1:0]   rsp_tail_priority,
   output logic                       rsp_is_empty
);

   op_type                   op_ff;
   logic signed [DATA_W-1:0] item_val_ff;
   logic signed [DATA_W-1:0] item_pri_ff;
   status_type               stat_ff, stat_in;

   logic signed [DATA_W-1:0] val_ff [DEPTH];
   logic signed [DATA_W-1:0] val_in [DEPTH];
   logic signed [DATA_W-1:0] pri_ff [DEPTH];
   logic signed [DATA_W-1:0] pri_in [DEPTH];
   logic signed [DATA_W-1:0] val_dn [DEPTH];
   logic signed [DATA_W-1:0] pri_dn [DEPTH];
   logic signed [DATA_W-1:0] val_up [DEPTH];
   logic signed [DATA_W-1:0] pri_up [DEPTH];
   logic [CW-1:0]            count_ff, count_in;

   logic [DEPTH-1:0] shift_sel;
   logic [DEPTH-1:0] shift_prev;
   logic             head_le;
   logic             empty;
   logic             full;

   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [COUNT_PORT_W-1:0]  rsp_count_ff;
   logic signed [DATA_W-1:0] rsp_head_val_ff;
   logic signed [DATA_W-1:0] rsp_head_pri_ff;
   logic signed [DATA_W-1:0] rsp_big_ff;
   logic signed [DATA_W-1:0] rsp_tail_ff;
   logic                     rsp_empty_ff;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(DEPTH));
   assign head_le = (item_pri_ff <= pri_ff[0]);

   // A slot moves up when it is occupied and the new entry sorts in front of it.
   // The array is always sorted, so the flags form a suffix of the occupied slots.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         shift_sel[i] = (CW'(i) < count_ff) && ((pri_ff[i] > item_pri_ff) || head_le);
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_nbr
         if (g == 0) begin : g_first
            assign shift_prev[g] = 1'b0;
            assign val_up[g]     = val_ff[g];
            assign pri_up[g]     = pri_ff[g];
         end else begin : g_rest
            assign shift_prev[g] = shift_sel[g-1];
            assign val_up[g]     = val_ff[g-1];
            assign pri_up[g]     = pri_ff[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign val_dn[g] = val_ff[g];
            assign pri_dn[g] = pri_ff[g];
         end else begin : g_low
            assign val_dn[g] = val_ff[g+1];
            assign pri_dn[g] = pri_ff[g+1];
         end
      end
   endgenerate

   always_comb begin
      val_in   = val_ff;
      pri_in   = pri_ff;
      count_in = count_ff;
      stat_in  = stat_ff;
      case (cmd.op)
         DP_EXEC: begin
            stat_in = STAT_DONE;
            case (op_ff)
               OP_INSERT: begin
                  if (full) begin
                     stat_in = STAT_FULL;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        if (shift_prev[i]) begin
                           val_in[i] = val_up[i];
                           pri_in[i] = pri_up[i];
                        end else if (shift_sel[i] || (CW'(i) == count_ff)) begin
                           val_in[i] = item_val_ff;
                           pri_in[i] = item_pri_ff;
                        end
                     end
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_REMOVE: begin
                  if (empty) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     val_in   = val_dn;
                     pri_in   = pri_dn;
                     count_in = count_ff - CW'(1);
                  end
               end
               OP_AGE_UP: begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (pri_ff[i] != PRI_MAX) pri_in[i] = pri_ff[i] + DATA_W'(1);
                  end
               end
               OP_AGE_DOWN: begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (pri_ff[i] != PRI_MIN) pri_in[i] = pri_ff[i] - DATA_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         // negative entries sit at the front; drop one per cycle
         DP_PURGE: begin
            val_in   = val_dn;
            pri_in   = pri_dn;
            count_in = count_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      pri_ff  <= pri_in;
      stat_ff <= stat_in;
      if (cmd.capture) begin
         op_ff       <= op_type'(req_operation);
         item_val_ff <= req_item_value;
         item_pri_ff <= req_item_priority;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= stat_ff;
         rsp_count_ff  <= COUNT_PORT_W'(count_ff);
         rsp_empty_ff  <= empty;
         if (empty) begin
            rsp_head_val_ff <= '0;
            rsp_head_pri_ff <= '0;
            rsp_big_ff      <= '0;
            rsp_tail_ff     <= '0;
         end else begin
            rsp_head_val_ff <= val_ff[0];
            rsp_head_pri_ff <= pri_ff[0];
            rsp_big_ff      <= root.vmax;
            rsp_tail_ff     <= root.pmax;
         end
      end
   end

   assign dp_stat.op       = op_ff;
   assign dp_stat.empty    = empty;
   assign dp_stat.head_neg = pri_ff[0][DATA_W-1];

   assign val_q = val_ff;
   assign pri_q = pri_ff;
   assign count = count_ff;

   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_head_value    = rsp_head_val_ff;
   assign rsp_head_priority = rsp_head_pri_ff;
   assign rsp_largest_value = rsp_big_ff;
   assign rsp_tail_priority = rsp_tail_ff;
   assign rsp_is_empty      = rsp_empty_ff;

endmodule

// ===== rtl/core/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: capture, execute, purge loop, max-tree drain, result handoff.
// ----------------------------------------------------------------------------
module spq_ctrl
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output cmd_type       cmd,
   input  dp_status_type dp_stat
);

   localparam int LEVELS = $clog2(DEPTH);
   localparam int DCW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   state_type      state_ff, state_in;
   logic [DCW-1:0] drain_ff, drain_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.capture  = 1'b0;
      cmd.op       = DP_NONE;
      cmd.load_rsp = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.op   = DP_EXEC;
            drain_in = '0;
            state_in = (dp_stat.op == OP_AGE_DOWN) ? ST_PURGE : ST_DRAIN;
         end
         ST_PURGE: begin
            if (!dp_stat.empty && dp_stat.head_neg) begin
               cmd.op = DP_PURGE;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         // array is stable here; let the registered max tree settle over its levels
         ST_DRAIN: begin
            if (drain_ff == DCW'(LEVELS - 1)) begin
               state_in = ST_DONE;
            end else begin
               drain_in = drain_ff + DCW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Priority queue of up to DEPTH (value, priority) entries kept sorted by
// ascending priority in a parallel-shift register array.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transaction (insert, remove head, age up,
//   age down with purge of negative priorities). Every request yields exactly
//   one rsp_* transaction with a status code, the count, the head entry, the
//   largest value and the tail priority after the operation.
//   After the request transaction the unit executes the operation, for age
//   down purges each negative head entry in turn, then lets the registered
//   max/tail reduction tree settle over the updated array before the response
//   loads and response valid rises. One request is in flight at a time and
//   the next one is taken the cycle after the response loads.
//   The response sits in an output register, so a new request is taken while
//   a finished response waits; if the receiver stalls, the sequencer holds the
//   next result in the datapath until the output register frees.
//   Reset empties the queue (count to zero) and drops any pending response;
//   the entry storage itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [DATA_W-1:0]  req_item_value,
   input  logic signed [DATA_W-1:0]  req_item_priority,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_PORT_W-1:0]   rsp_entry_count,
   output logic signed [DATA_W-1:0]  rsp_head_value,
   output logic signed [DATA_W-1:0]  rsp_head_priority,
   output logic signed [DATA_W-1:0]  rsp_largest_value,
   output logic signed [DATA_W-1:0]  rsp_tail_priority,
   output logic                      rsp_is_empty
);

   localparam int CW = $clog2(DEPTH + 1);

   cmd_type                  cmd;
   dp_status_type            dp_stat;
   logic signed [DATA_W-1:0] val_q [DEPTH];
   logic signed [DATA_W-1:0] pri_q [DEPTH];
   logic [CW-1:0]            count;
   node_type                 root;

   spq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .dp_stat   (dp_stat)
   );

   spq_datapath #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_stat           (dp_stat),
      .req_operation     (req_operation),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .val_q             (val_q),
      .pri_q             (pri_q),
      .count             (count),
      .root              (root),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_head_value    (rsp_head_value),
      .rsp_head_priority (rsp_head_priority),
      .rsp_largest_value (rsp_largest_value),
      .rsp_tail_priority (rsp_tail_priority),
      .rsp_is_empty      (rsp_is_empty)
   );

   spq_max_tree #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_max_tree (
      .clock (clock),
      .val_q (val_q),
      .pri_q (pri_q),
      .count (count),
      .root  (root)
   );

endmodule
